### sv/klvt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// keyed latest-value table. No dependencies.
package klvt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_BYTES     = 12;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int OUT_IDX_W = 6;

	localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_APPEND    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd3;

	typedef struct packed {
		logic load;      // capture a new transaction, restart scan
		logic scan;      // advance the key scan
		logic data;      // apply update / fetch entry data
		logic out_load;  // load the output register
	} klvt_cmd_t;

	typedef struct packed {
		logic scan_done;
	} klvt_sts_t;

endpackage

### sv/keyed_latest_value_table_unit.sv
// Keyed latest-value table, top level: klvt_ctrl sequences klvt_dp.
// Each transaction is captured, then scanned (one stored key read per cycle), then
// given its data access; its result then moves to the output register.
// The next transaction is accepted in the cycle after its result is loaded; a result
// may wait in the output register.
// Reset clears the entry count and control state; no memory clearing pass.
module keyed_latest_value_table_unit import klvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [OP_W-1:0]      opcode,
	input  logic [63:0]          key_low,
	input  logic [31:0]          key_high,
	input  logic [31:0]          event_time,
	input  logic [63:0]          bid_word,
	input  logic [63:0]          ask_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [STATUS_W-1:0]  status,
	output logic                 found,
	output logic [OUT_IDX_W-1:0] entry_index,
	output logic                 at_or_after,
	output logic [31:0]          stored_time,
	output logic [63:0]          stored_bid,
	output logic [63:0]          stored_ask
);

	klvt_cmd_t cmd;
	klvt_sts_t sts;

	klvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	klvt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (opcode),
		.key_low     (key_low),
		.key_high    (key_high),
		.event_time  (event_time),
		.bid_word    (bid_word),
		.ask_word    (ask_word),
		.status      (status),
		.found       (found),
		.entry_index (entry_index),
		.at_or_after (at_or_after),
		.stored_time (stored_time),
		.stored_bid  (stored_bid),
		.stored_ask  (stored_ask)
	);

endmodule

### sv/klvt_ctrl.sv
// Controller FSM for the keyed latest-value table: sequences capture, scan,
// data access and response. Depends on klvt_pkg.
module klvt_ctrl import klvt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  klvt_sts_t sts,
	output klvt_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DATA = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.scan     = 1'b0;
		cmd.data     = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = S_DATA;
			end
			S_DATA: begin
				cmd.data = 1'b1;
				state_d  = S_RESP;
			end
			S_RESP: begin
				// hold the result until the output register frees up
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_load_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == S_IDLE) && in_valid)
		else $error("load outside idle");
	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("output not valid after load");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid || out_ready)
		else $error("output register overrun");

endmodule

### sv/klvt_dp.sv
// Datapath for the keyed latest-value table: key canonicalization, key and
// entry memories, scan pipeline, update logic and output register.
// Depends on klvt_pkg.
module klvt_dp import klvt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  klvt_cmd_t            cmd,
	output klvt_sts_t            sts,
	input  logic [OP_W-1:0]      opcode,
	input  logic [63:0]          key_low,
	input  logic [31:0]          key_high,
	input  logic [31:0]          event_time,
	input  logic [63:0]          bid_word,
	input  logic [63:0]          ask_word,
	output logic [STATUS_W-1:0]  status,
	output logic                 found,
	output logic [OUT_IDX_W-1:0] entry_index,
	output logic                 at_or_after,
	output logic [31:0]          stored_time,
	output logic [63:0]          stored_bid,
	output logic [63:0]          stored_ask
);

	// entry memories, no reset; only slots below count_q are matched or returned
	logic [63:0] key_lo_mem [TABLE_ENTRIES];
	logic [31:0] key_hi_mem [TABLE_ENTRIES];
	logic [31:0] time_mem   [TABLE_ENTRIES];
	logic [63:0] bid_mem    [TABLE_ENTRIES];
	logic [63:0] ask_mem    [TABLE_ENTRIES];

	logic [63:0]         canon_lo;
	logic [31:0]         canon_hi;

	logic [OP_W-1:0]     op_q;
	logic [63:0]         key_lo_q;
	logic [31:0]         key_hi_q;
	logic [31:0]         time_q;
	logic [63:0]         bid_q;
	logic [63:0]         ask_q;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    addr_q;
	logic                issue;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [63:0]         rd_key_lo_s1;
	logic [31:0]         rd_key_hi_s1;
	logic                match;
	logic                hit_q;
	logic [IDX_W-1:0]    slot_q;

	logic [IDX_W-1:0]    data_addr;
	logic                full;
	logic [31:0]         rd_time_q;
	logic [63:0]         rd_bid_q;
	logic [63:0]         rd_ask_q;
	logic [STATUS_W-1:0] res_status_q;
	logic                res_found_q;
	logic [OUT_IDX_W-1:0] res_idx_q;

	// a key ends at its first zero byte or after KEY_BYTES bytes
	always_comb begin
		logic keep;
		keep     = 1'b1;
		canon_lo = '0;
		canon_hi = '0;
		for (int i = 0; i < 8; i++) begin
			keep = keep && (key_low[8*i +: 8] != 8'd0) && (i < KEY_BYTES);
			if (keep) canon_lo[8*i +: 8] = key_low[8*i +: 8];
		end
		for (int i = 0; i < 4; i++) begin
			keep = keep && (key_high[8*i +: 8] != 8'd0) && (i + 8 < KEY_BYTES);
			if (keep) canon_hi[8*i +: 8] = key_high[8*i +: 8];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= opcode;
			key_lo_q <= canon_lo;
			key_hi_q <= canon_hi;
			time_q   <= event_time;
			bid_q    <= bid_word;
			ask_q    <= ask_word;
		end
	end

	assign issue = !hit_q && (addr_q < count_q);
	assign match = rd_vld_s1 && (rd_key_lo_s1 == key_lo_q) && (rd_key_hi_s1 == key_hi_q);
	assign sts.scan_done = hit_q || ((addr_q >= count_q) && !rd_vld_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.load) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else if (cmd.scan) begin
			rd_vld_s1 <= issue;
			if (issue) addr_q <= addr_q + CNT_W'(1);
			// slots are scanned in order, so the first hit is kept
			if (match && !hit_q) hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_idx_s1    <= addr_q[IDX_W-1:0];
			rd_key_lo_s1 <= key_lo_mem[addr_q[IDX_W-1:0]];
			rd_key_hi_s1 <= key_hi_mem[addr_q[IDX_W-1:0]];
			if (match && !hit_q) slot_q <= rd_idx_s1;
		end
	end

	assign full      = (count_q >= CNT_W'(TABLE_ENTRIES));
	assign data_addr = hit_q ? slot_q : count_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.data && (op_q == OP_UPDATE) && (time_q != 32'd0) && !hit_q
				&& !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.data) begin
			rd_time_q <= time_mem[data_addr];
			rd_bid_q  <= bid_mem[data_addr];
			rd_ask_q  <= ask_mem[data_addr];
			if ((op_q == OP_UPDATE) && (time_q != 32'd0) && (hit_q || !full)) begin
				time_mem[data_addr] <= time_q;
				bid_mem[data_addr]  <= bid_q;
				ask_mem[data_addr]  <= ask_q;
				if (!hit_q) begin
					key_lo_mem[data_addr] <= key_lo_q;
					key_hi_mem[data_addr] <= key_hi_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.data) begin
			res_status_q <= ST_OVERWRITE;
			res_found_q  <= 1'b0;
			res_idx_q    <= '0;
			case (op_q)
				OP_UPDATE: begin
					if (time_q == 32'd0) begin
						res_status_q <= ST_IGNORED;
					end else if (hit_q) begin
						res_found_q <= 1'b1;
						res_idx_q   <= OUT_IDX_W'(slot_q);
					end else if (full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_status_q <= ST_APPEND;
						res_idx_q    <= OUT_IDX_W'(count_q[IDX_W-1:0]);
					end
				end
				OP_QUERY, OP_READ: begin
					res_found_q <= hit_q;
					res_idx_q   <= hit_q ? OUT_IDX_W'(slot_q) : '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status      <= res_status_q;
			found       <= res_found_q;
			entry_index <= res_idx_q;
			at_or_after <= (op_q == OP_QUERY) && (!hit_q || (time_q >= rd_time_q));
			stored_time <= ((op_q == OP_READ) && hit_q) ? rd_time_q : '0;
			stored_bid  <= ((op_q == OP_READ) && hit_q) ? rd_bid_q : '0;
			stored_ask  <= ((op_q == OP_READ) && hit_q) ? rd_ask_q : '0;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count above table size");
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> (CNT_W'(slot_q) < count_q))
		else $error("hit slot beyond entry count");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count moved by more than one");
	a_count_hold_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |=> $stable(count_q))
		else $error("entry count changed during scan");

endmodule
